// ----- hw/rtl/bilinear_frame_scaler_assert.svh -----
// Assertion macros for the bilinear frame scaler checker
`ifndef BILINEAR_FRAME_SCALER_ASSERT_SVH
`define BILINEAR_FRAME_SCALER_ASSERT_SVH

// same-cycle implication
`define FSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsc check failed");

// next-cycle implication
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsc check failed");

`endif

// ----- hw/rtl/fsc_pkg.sv -----
// Shared constants, types and blend functions of the bilinear frame scaler
`default_nettype none
package fsc_pkg;

  localparam int SRC_W      = 640;
  localparam int SRC_H      = 480;
  localparam int BANK_COLS  = SRC_W / 2;
  localparam int BANK_DEPTH = (SRC_W / 2) * (SRC_H / 2);
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int NBANK      = 4;

  localparam int STEP_W  = 26;
  localparam int STEP_CW = $clog2(STEP_W + 1);
  localparam logic [STEP_W-1:0] STEP_DVD = STEP_W'(SRC_W) << 16;

  localparam logic [12:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [12:0] OUT_HEIGHT_RST = 13'd480;

  localparam logic CFG_OUT_WIDTH  = 1'b0;
  localparam logic CFG_OUT_HEIGHT = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [7:0]  ALPHA    = 8'hFF;
  localparam logic [25:0] XCAP     = 26'((SRC_W - 1) << 16);
  localparam logic [24:0] YCAP     = 25'((SRC_H - 1) << 16);
  localparam logic [24:0] HALF_PIX = 25'd32768;
  localparam logic [9:0]  LAST_COL = 10'(SRC_W - 1);
  localparam logic [8:0]  LAST_ROW = 9'(SRC_H - 1);

  localparam int DIV_STEPS = 25;
  localparam int ST_DIV0   = 1;
  localparam int ST_ADDR   = ST_DIV0 + DIV_STEPS + 1;
  localparam int ST_READ   = ST_ADDR + 1;
  localparam int ST_HORZ   = ST_READ + 1;
  localparam int ST_OUT    = ST_HORZ + 1;
  localparam int NST       = ST_OUT + 1;

  typedef struct packed {
    logic                      op;
    logic [9:0]                wcol;
    logic [8:0]                wrow;
    logic [23:0]               wrgb;
    logic [11:0]               ox;
    logic [11:0]               oy;
    logic [9:0]                mlo;
    logic [12:0]               rem;
    logic [24:0]               q;
    logic                      ovf;
    logic [37:0]               prodx;
    logic [25:0]               fx;
    logic [NBANK*BANK_AW-1:0]  addr;
    logic                      wen;
    logic [1:0]                wbank;
    logic                      x0p;
    logic                      x1p;
    logic                      y0p;
    logic                      y1p;
    logic [7:0]                wx;
    logic [7:0]                wy;
    logic [23:0]               top;
    logic [23:0]               bot;
    logic [23:0]               pix;
  } pl_t;

  function automatic logic [7:0] lerp8(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] w);
    logic [16:0] acc;
    acc = 17'(x) * 17'(9'd256 - {1'b0, w}) + 17'(y) * 17'(w);
    return acc[15:8];
  endfunction

  function automatic logic [23:0] lerp24(input logic [23:0] a, input logic [23:0] b,
                                         input logic [7:0] w);
    return {lerp8(a[23:16], b[23:16], w), lerp8(a[15:8], b[15:8], w),
            lerp8(a[7:0], b[7:0], w)};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fsc_step_div.sv -----
// Serial divider that derives the horizontal step from the output width
`default_nettype none
module fsc_step_div import fsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [12:0]       divisor,
  output logic                   busy,
  output logic [STEP_W-1:0]      quotient
);

  logic               busy_r;
  logic [STEP_CW-1:0] cnt_r;
  logic [12:0]        dvs_r;
  logic [12:0]        rem_r;
  logic [STEP_W-1:0]  quo_r;
  logic [STEP_CW-1:0] idx;
  logic [13:0]        tr;
  logic               ge;

  always_comb begin
    idx = cnt_r - STEP_CW'(1);
    tr  = {rem_r, STEP_DVD[idx[$clog2(STEP_W)-1:0]]};
    ge  = tr >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_CW'(STEP_W);
    end else if (busy_r) begin
      cnt_r <= idx;
      if (cnt_r == STEP_CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= '0;
      dvs_r <= (divisor == 13'd0) ? 13'd1 : divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 13'(tr - {1'b0, dvs_r}) : tr[12:0];
      quo_r <= {quo_r[STEP_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- hw/rtl/fsc_frame_bank.sv -----
// One quarter of the source frame store, registered read
`default_nettype none
module fsc_frame_bank import fsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               we,
  input  wire logic [BANK_AW-1:0] addr,
  input  wire logic [23:0]        wdata,
  output logic [23:0]             rdata
);

  logic [23:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bilinear_frame_scaler.sv -----
// Top level of the bilinear frame scaler: item pipeline around a banked frame store
//
// Input channel in_*: opcode 0 writes src_rgb at (src_col, src_row) of the
// 640x480 frame store; opcode 1 samples output pixel (out_col, out_row).
// Result channel out_*: one out_pixel per sample item, none per write item.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 out_width, 1 out_height). The user must write only while the block is
// idle; the block itself does not enforce this.
// Throughput: one item per cycle while in_stall is low; the row position
// divider is a 25-stage pipeline and the frame store is four column/row parity
// banks, so the four neighbours of a sample are read in the same cycle.
// Reset and every out_width write start a serial step division; in_stall
// stays high until it finishes.
// When the receiver stalls, the output register holds and each pipeline stage
// keeps taking items while it or any stage ahead of it is still empty.
`default_nettype none
module bilinear_frame_scaler import fsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [9:0]  in_src_col,
  input  wire logic [8:0]  in_src_row,
  input  wire logic [23:0] in_src_rgb,
  input  wire logic [11:0] in_out_col,
  input  wire logic [11:0] in_out_row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  logic [12:0]       out_width_r;
  logic [12:0]       out_height_r;
  logic [12:0]       h_eff;
  logic              init_r;
  logic              step_start;
  logic              step_busy;
  logic [12:0]       step_dvs;
  logic [STEP_W-1:0] stepx;

  pl_t               p_r   [NST];
  pl_t               p_nxt [NST];
  logic [NST-1:0]    v_r;
  logic [NST-1:0]    v_in;
  logic [NST-1:0]    rdy;
  logic              in_acc;

  logic [NBANK-1:0]  bank_en;
  logic [NBANK-1:0]  bank_we;
  logic [23:0]       bank_rd [NBANK];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
      init_r       <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OUT_WIDTH:  out_width_r  <= cfg_wdata;
          CFG_OUT_HEIGHT: out_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign step_start = init_r || (cfg_we && cfg_index == CFG_OUT_WIDTH);
  assign step_dvs   = (cfg_we && cfg_index == CFG_OUT_WIDTH) ? cfg_wdata : out_width_r;
  assign h_eff      = (out_height_r == 13'd0) ? 13'd1 : out_height_r;

  fsc_step_div u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (step_start),
    .divisor  (step_dvs),
    .busy     (step_busy),
    .quotient (stepx)
  );

  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_stall = step_busy || init_r || !rdy[0];
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    v_in[0] = in_acc;
    for (int i = 1; i < NST; i++) begin
      v_in[i] = v_r[i-1];
    end
    v_in[ST_READ] = v_r[ST_ADDR] && (p_r[ST_ADDR].op == OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  always_comb begin
    logic [12:0]        odd;
    logic [21:0]        m;
    logic [13:0]        tr;
    logic               ge;
    logic signed [26:0] fx0;
    logic signed [39:0] fxs;
    logic [24:0]        fy;
    logic [9:0]         x0;
    logic [9:0]         x1;
    logic [8:0]         y0;
    logic [8:0]         y1;
    logic [9:0]         col;
    logic [8:0]         row;
    logic [1:0]         bsel;
    pl_t                s;

    for (int i = 0; i < NST; i++) begin
      p_nxt[i] = p_r[i];
    end

    s       = p_r[0];
    s.op    = in_opcode;
    s.wcol  = in_src_col;
    s.wrow  = in_src_row;
    s.wrgb  = in_src_rgb;
    s.ox    = in_out_col;
    s.oy    = in_out_row;
    p_nxt[0] = s;

    s       = p_r[0];
    odd     = {s.oy, 1'b1};
    m       = ({9'd0, odd} << 9) - ({9'd0, odd} << 5);
    s.mlo   = m[9:0];
    s.rem   = {1'b0, m[21:10]};
    s.ovf   = {1'b0, m[21:10]} >= h_eff;
    s.q     = '0;
    s.prodx = 38'(s.ox) * 38'(stepx);
    p_nxt[ST_DIV0] = s;

    fx0 = $signed({2'b00, stepx[STEP_W-1:1]}) - 27'sd32768;
    for (int i = ST_DIV0 + 1; i <= ST_DIV0 + DIV_STEPS; i++) begin
      s     = p_r[i-1];
      tr    = {s.rem, s.mlo[9]};
      ge    = tr >= {1'b0, h_eff};
      s.rem = ge ? 13'(tr - {1'b0, h_eff}) : tr[12:0];
      s.q   = {s.q[23:0], ge};
      s.mlo = {s.mlo[8:0], 1'b0};
      if (i == ST_DIV0 + 1) begin
        fxs = $signed({2'b00, s.prodx}) + 40'(fx0);
        if (fxs < 0) begin
          s.fx = '0;
        end else if (fxs > $signed({14'd0, XCAP})) begin
          s.fx = XCAP;
        end else begin
          s.fx = fxs[25:0];
        end
      end
      p_nxt[i] = s;
    end

    s = p_r[ST_ADDR-1];
    if (s.ovf || s.q > YCAP + HALF_PIX) begin
      fy = YCAP;
    end else if (s.q < HALF_PIX) begin
      fy = '0;
    end else begin
      fy = s.q - HALF_PIX;
    end
    x0 = s.fx[25:16];
    y0 = fy[24:16];
    x1 = (x0 == LAST_COL) ? x0 : x0 + 10'd1;
    y1 = (y0 == LAST_ROW) ? y0 : y0 + 9'd1;
    s.wx  = s.fx[15:8];
    s.wy  = fy[15:8];
    s.x0p = x0[0];
    s.x1p = x1[0];
    s.y0p = y0[0];
    s.y1p = y1[0];
    s.wen   = (s.op == OP_WRITE) && (s.wcol <= LAST_COL) && (s.wrow <= LAST_ROW);
    s.wbank = {s.wrow[0], s.wcol[0]};
    for (int b = 0; b < NBANK; b++) begin
      bsel = 2'(b);
      if (s.op == OP_WRITE) begin
        col = s.wcol;
        row = s.wrow;
      end else begin
        col = (x0[0] == bsel[0]) ? x0 : x1;
        row = (y0[0] == bsel[1]) ? y0 : y1;
      end
      s.addr[b*BANK_AW +: BANK_AW] = BANK_AW'(BANK_AW'(row[8:1]) * BANK_AW'(BANK_COLS))
                                     + BANK_AW'(col[9:1]);
    end
    p_nxt[ST_ADDR] = s;

    p_nxt[ST_READ] = p_r[ST_ADDR];

    s     = p_r[ST_READ];
    s.top = lerp24(bank_rd[{s.y0p, s.x0p}], bank_rd[{s.y0p, s.x1p}], s.wx);
    s.bot = lerp24(bank_rd[{s.y1p, s.x0p}], bank_rd[{s.y1p, s.x1p}], s.wx);
    p_nxt[ST_HORZ] = s;

    s     = p_r[ST_HORZ];
    s.pix = lerp24(s.top, s.bot, s.wy);
    p_nxt[ST_OUT] = s;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        p_r[i] <= p_nxt[i];
      end
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    assign bank_we[b] = v_r[ST_ADDR] && rdy[ST_READ] && p_r[ST_ADDR].wen
                        && (p_r[ST_ADDR].wbank == 2'(b));
    assign bank_en[b] = bank_we[b]
                        || (v_r[ST_ADDR] && rdy[ST_READ] && p_r[ST_ADDR].op == OP_SAMPLE);

    fsc_frame_bank u_bank (
      .clk   (clk),
      .en    (bank_en[b]),
      .we    (bank_we[b]),
      .addr  (p_r[ST_ADDR].addr[b*BANK_AW +: BANK_AW]),
      .wdata (p_r[ST_ADDR].wrgb),
      .rdata (bank_rd[b])
    );
  end

  assign out_valid = v_r[ST_OUT];
  assign out_pixel = {ALPHA, p_r[ST_OUT].pix};

endmodule
`default_nettype wire

// ----- hw/rtl/fsc_checker.sv -----
// Port-level checker for the bilinear frame scaler and its bind
`default_nettype none
`include "bilinear_frame_scaler_assert.svh"
module fsc_checker import fsc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_pixel,
  input wire logic        cfg_we,
  input wire logic        cfg_index
);

  `FSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel))
  `FSC_ASSERT_NOW(a_alpha, out_valid, out_pixel[31:24] == ALPHA)
  `FSC_ASSERT_NEXT(a_step_lock, cfg_we && cfg_index == CFG_OUT_WIDTH, in_stall)
  `FSC_ASSERT_NOW(a_init_lock, $rose(rst_n), in_stall)

endmodule

bind bilinear_frame_scaler fsc_checker u_fsc_checker (.*);
`default_nettype wire

// ----- tb/tb_bilinear_frame_scaler.sv -----
// Self-checking testbench of the bilinear frame scaler with a scoreboard and predictor
`timescale 1ns / 100ps
module tb_bilinear_frame_scaler;
  import fsc_pkg::*;

  localparam int FRAME_PIX = SRC_W * SRC_H;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 40;

  class scaler_scoreboard;
    logic [23:0] frame[FRAME_PIX];
    bit written[FRAME_PIX];
    logic [12:0] dst_w = OUT_WIDTH_RST;
    logic [12:0] dst_h = OUT_HEIGHT_RST;
    logic [31:0] pending_pixels[$];
    int mismatches = 0;

    function void map_point(input logic [11:0] ox, input logic [11:0] oy,
                            output int x0, output int x1, output int y0,
                            output int y1, output logic [7:0] wx,
                            output logic [7:0] wy);
      longint w, h, stepx, fx, fy;
      w = (dst_w == 0) ? 1 : dst_w;
      h = (dst_h == 0) ? 1 : dst_h;
      stepx = (longint'(SRC_W) << 16) / w;
      fx = (longint'(SRC_W) << 15) / w - 32768 + longint'(ox) * stepx;
      fy = ((2 * longint'(oy) + 1) * SRC_H * 32768) / h - 32768;
      if (fx < 0) fx = 0;
      if (fx > (longint'(SRC_W - 1) << 16)) fx = longint'(SRC_W - 1) << 16;
      if (fy < 0) fy = 0;
      if (fy > (longint'(SRC_H - 1) << 16)) fy = longint'(SRC_H - 1) << 16;
      x0 = int'(fx >> 16);
      y0 = int'(fy >> 16);
      x1 = (x0 + 1 < SRC_W) ? x0 + 1 : x0;
      y1 = (y0 + 1 < SRC_H) ? y0 + 1 : y0;
      wx = fx[15:8];
      wy = fy[15:8];
    endfunction

    function logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                              input logic [7:0] wt, input logic [31:0] mask);
      logic [31:0] s;
      s = 32'd256 - wt;
      return ((((a & mask) * s) + ((b & mask) * wt)) >> 8) & mask;
    endfunction

    function logic [31:0] blend_pixel(input logic [11:0] ox, input logic [11:0] oy);
      int x0, x1, y0, y1;
      logic [7:0] wx, wy;
      logic [31:0] a, b, c, d;
      map_point(ox, oy, x0, x1, y0, y1, wx, wy);
      a = frame[y0 * SRC_W + x0];
      b = frame[y0 * SRC_W + x1];
      c = frame[y1 * SRC_W + x0];
      d = frame[y1 * SRC_W + x1];
      return 32'hFF000000
        | mix(mix(a, b, wx, 32'hFF00FF), mix(c, d, wx, 32'hFF00FF), wy, 32'hFF00FF)
        | mix(mix(a, b, wx, 32'h00FF00), mix(c, d, wx, 32'h00FF00), wy, 32'h00FF00);
    endfunction

    function void note_item(input logic op, input logic [9:0] col, input logic [8:0] row,
                            input logic [23:0] rgb, input logic [11:0] ox,
                            input logic [11:0] oy);
      if (op == OP_WRITE) begin
        if (col < SRC_W && row < SRC_H) begin
          frame[row * SRC_W + col] = rgb;
          written[row * SRC_W + col] = 1'b1;
        end
      end else begin
        pending_pixels.push_back(blend_pixel(ox, oy));
      end
    endfunction

    function void check_pixel(input logic [31:0] got);
      logic [31:0] want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected out_pixel %h", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("out_pixel mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [9:0] in_src_col;
  logic [8:0] in_src_row;
  logic [23:0] in_src_rgb;
  logic [11:0] in_out_col;
  logic [11:0] in_out_row;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_pixel;
  logic cfg_we;
  logic cfg_index;
  logic [12:0] cfg_wdata;

  scaler_scoreboard sb;
  bit quiet_send;
  bit quiet_recv;
  int cycles;

  bilinear_frame_scaler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_src_col(in_src_col), .in_src_row(in_src_row), .in_src_rgb(in_src_rgb),
    .in_out_col(in_out_col), .in_out_row(in_out_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bilinear_frame_scaler: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_pixel);
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = quiet_recv ? 0 : $urandom_range(11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic op, input logic [9:0] col, input logic [8:0] row,
                           input logic [23:0] rgb, input logic [11:0] ox,
                           input logic [11:0] oy);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_src_col <= col;
    in_src_row <= row;
    in_src_rgb <= rgb;
    in_out_col <= ox;
    in_out_row <= oy;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, col, row, rgb, ox, oy);
  endtask

  task automatic write_pixel(input int col, input int row, input logic [23:0] rgb);
    send_item(OP_WRITE, 10'(col), 9'(row), rgb, 12'($urandom), 12'($urandom));
  endtask

  // fill any unwritten neighbor before the sample goes in
  task automatic sample_pixel(input logic [11:0] ox, input logic [11:0] oy);
    int x0, x1, y0, y1;
    logic [7:0] wx, wy;
    sb.map_point(ox, oy, x0, x1, y0, y1, wx, wy);
    if (!sb.written[y0 * SRC_W + x0]) write_pixel(x0, y0, 24'($urandom));
    if (!sb.written[y0 * SRC_W + x1]) write_pixel(x1, y0, 24'($urandom));
    if (!sb.written[y1 * SRC_W + x0]) write_pixel(x0, y1, 24'($urandom));
    if (!sb.written[y1 * SRC_W + x1]) write_pixel(x1, y1, 24'($urandom));
    send_item(OP_SAMPLE, 10'($urandom), 9'($urandom), 24'($urandom), ox, oy);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_OUT_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_OUT_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.dst_w = w;
    sb.dst_h = h;
  endtask

  task automatic random_phase(input int items);
    int k;
    int pick;
    for (k = 0; k < items; k++) begin
      if (k % 60 == 0) begin
        quiet_send = ($urandom_range(3) == 0);
        quiet_recv = ($urandom_range(3) == 0);
      end
      pick = $urandom_range(9);
      if (pick < 5) begin
        if ($urandom_range(3) == 0)
          sample_pixel(12'($urandom), 12'($urandom));
        else
          sample_pixel(12'($urandom_range(sb.dst_w)), 12'($urandom_range(sb.dst_h)));
      end else if (pick < 9) begin
        write_pixel($urandom_range(SRC_W - 1), $urandom_range(SRC_H - 1), 24'($urandom));
      end else begin
        send_item(OP_WRITE, 10'($urandom), 9'($urandom_range(511, SRC_H)), 24'($urandom),
                  12'($urandom), 12'($urandom));
      end
    end
    quiet_send = 0;
    quiet_recv = 0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    quiet_send = 0;
    quiet_recv = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_WRITE;
    in_src_col <= '0;
    in_src_row <= '0;
    in_src_rgb <= '0;
    in_out_col <= '0;
    in_out_row <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_OUT_WIDTH;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(SRC_W - 1, SRC_H - 1, 24'h000000);
    send_item(OP_WRITE, 10'h3FF, 9'h1FF, 24'hFFFFFF, 12'hFFF, 12'hFFF);
    send_item(OP_WRITE, 10'd0, 9'(SRC_H), 24'h123456, 12'd0, 12'd0);
    send_item(OP_WRITE, 10'(SRC_W), 9'd0, 24'h654321, 12'd0, 12'd0);
    sample_pixel(12'd0, 12'd0);
    sample_pixel(12'hFFF, 12'hFFF);
    sample_pixel(12'd639, 12'd479);
    sample_pixel(12'd320, 12'd240);
    sample_pixel(12'd0, 12'hFFF);
    sample_pixel(12'hFFF, 12'd0);

    // hold the sender until the pipe drains
    wait_idle();
    sample_pixel(12'd100, 12'd50);

    random_phase(110);
    set_size(13'd1, 13'd1);
    sample_pixel(12'd0, 12'd0);
    random_phase(70);
    set_size(13'd4096, 13'd4096);
    sample_pixel(12'd4095, 12'd4095);
    sample_pixel(12'd0, 12'd0);
    random_phase(85);
    set_size(13'd0, 13'd8191);
    random_phase(70);
    set_size(13'd8191, 13'd0);
    random_phase(70);
    set_size(13'd320, 13'd960);
    random_phase(85);
    set_size(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
    random_phase(75);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb_bilinear_frame_scaler: clean");
    end else begin
      $display("tb_bilinear_frame_scaler: errors");
    end
    $finish;
  end

endmodule
